[hdl/length_prefixed_deframer_assert.svh]
// Assertion macros for the length-prefixed deframer.
// Used by the top level only; no other dependencies.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define LPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("length_prefixed_deframer: assertion failed");
`define LPD_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("length_prefixed_deframer: forbidden condition seen");
`else
`define LPD_ASSERT(lbl, clk, rst_n, prop)
`define LPD_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

[hdl/lpd_pkg.sv]
// Shared types and constants of the length-prefixed deframer.
// No dependencies; used by every module of the block.
package lpd_pkg;

  localparam int unsigned LPD_HDR_LEN     = 4;
  localparam int unsigned LPD_LEN_W       = 17;
  localparam int unsigned LPD_BEAT_W      = $clog2(LPD_HDR_LEN);
  localparam int unsigned LPD_FIFO_DEPTH  = 4;
  localparam logic [LPD_LEN_W-1:0] LPD_MAX_LEN_RESET = 17'd4096;
  localparam logic [LPD_BEAT_W-1:0] LPD_LAST_BEAT = LPD_BEAT_W'(LPD_HDR_LEN - 1);

  typedef enum logic [1:0] {
    RUN_BODY,
    RUN_HEADER,
    RUN_DROP
  } lpd_kind_t;

  typedef struct packed {
    lpd_kind_t   kind;
    logic [31:0] data;
    logic        last;
  } lpd_run_t;

endpackage

[hdl/lpd_parser.sv]
// Header collection, length check and packet tracking of the deframer.
// Depends on lpd_pkg; emits one run descriptor per beat that yields results.
module lpd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_chunk_end,
  input  logic                          fifo_full,
  input  logic                          cfg_valid,
  input  logic [lpd_pkg::LPD_LEN_W-1:0] cfg_max_packet_len,
  output logic                          push,
  output lpd_pkg::lpd_run_t             push_run
);

  logic [lpd_pkg::LPD_LEN_W-1:0]  max_len_r;
  logic [23:0]                    header_r, header_nxt;
  logic [lpd_pkg::LPD_BEAT_W-1:0] count_r, count_nxt;
  logic [lpd_pkg::LPD_LEN_W-1:0]  remaining_r, remaining_nxt;
  logic                           discarding_r, discarding_nxt;
  logic                           accept;
  logic [31:0]                    hdr_word;
  logic                           bad_len;

  assign accept   = in_valid & ~fifo_full;
  assign hdr_word = {header_r, in_data_byte};
  assign bad_len  = (hdr_word < 32'(lpd_pkg::LPD_HDR_LEN)) ||
                    (hdr_word > {{(32 - lpd_pkg::LPD_LEN_W){1'b0}}, max_len_r});

  always_comb begin
    header_nxt     = header_r;
    count_nxt      = count_r;
    remaining_nxt  = remaining_r;
    discarding_nxt = discarding_r;
    push           = 1'b0;
    push_run.kind  = lpd_pkg::RUN_BODY;
    push_run.data  = {24'd0, in_data_byte};
    push_run.last  = 1'b0;
    if (accept) begin
      if (discarding_r) begin
        if (in_chunk_end) begin
          discarding_nxt = 1'b0;
        end
      end else if (remaining_r != '0) begin
        push          = 1'b1;
        push_run.kind = lpd_pkg::RUN_BODY;
        push_run.last = (remaining_r == lpd_pkg::LPD_LEN_W'(1));
        remaining_nxt = remaining_r - lpd_pkg::LPD_LEN_W'(1);
      end else if (count_r != lpd_pkg::LPD_LAST_BEAT) begin
        header_nxt = hdr_word[23:0];
        count_nxt  = count_r + lpd_pkg::LPD_BEAT_W'(1);
      end else begin
        header_nxt = '0;
        count_nxt  = '0;
        push       = 1'b1;
        if (bad_len) begin
          push_run.kind  = lpd_pkg::RUN_DROP;
          discarding_nxt = ~in_chunk_end;
        end else begin
          push_run.kind = lpd_pkg::RUN_HEADER;
          push_run.data = hdr_word;
          remaining_nxt = hdr_word[lpd_pkg::LPD_LEN_W-1:0] -
                          lpd_pkg::LPD_LEN_W'(lpd_pkg::LPD_HDR_LEN);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= lpd_pkg::LPD_MAX_LEN_RESET;
      header_r     <= '0;
      count_r      <= '0;
      remaining_r  <= '0;
      discarding_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_max_packet_len;
      end
      header_r     <= header_nxt;
      count_r      <= count_nxt;
      remaining_r  <= remaining_nxt;
      discarding_r <= discarding_nxt;
    end
  end

endmodule

[hdl/lpd_run_fifo.sv]
// Small queue of run descriptors between the parser and the serializer.
// Depends on lpd_pkg for the descriptor type.
module lpd_run_fifo #(
  parameter int unsigned DEPTH = lpd_pkg::LPD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpd_pkg::lpd_run_t push_run,
  input  logic              pop,
  output lpd_pkg::lpd_run_t head,
  output logic              head_valid,
  output logic              full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_pkg::lpd_run_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign head       = mem[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

endmodule

[hdl/lpd_serializer.sv]
// Output register that expands run descriptors into result beats.
// Depends on lpd_pkg; a header run becomes four beats, other runs one.
module lpd_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  lpd_pkg::lpd_run_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_out_byte,
  output logic              out_packet_first,
  output logic              out_packet_last,
  output logic              out_frame_dropped,
  output logic              out_run_last
);

  logic                           valid_r, valid_nxt;
  logic [lpd_pkg::LPD_BEAT_W-1:0] beat_r, beat_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           first_r, first_nxt;
  logic                           last_r, last_nxt;
  logic                           drop_r, drop_nxt;
  logic                           run_last_r, run_last_nxt;
  logic                           load;

  assign load = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt    = valid_r;
    beat_nxt     = beat_r;
    byte_nxt     = byte_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    drop_nxt     = drop_r;
    run_last_nxt = run_last_r;
    pop          = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        case (head.kind)
          lpd_pkg::RUN_HEADER: begin
            byte_nxt     = 8'(head.data >> {lpd_pkg::LPD_LAST_BEAT - beat_r, 3'b000});
            first_nxt    = (beat_r == '0);
            last_nxt     = (beat_r == lpd_pkg::LPD_LAST_BEAT) &&
                           (head.data == 32'(lpd_pkg::LPD_HDR_LEN));
            drop_nxt     = 1'b0;
            run_last_nxt = (beat_r == lpd_pkg::LPD_LAST_BEAT);
            if (beat_r == lpd_pkg::LPD_LAST_BEAT) begin
              pop      = 1'b1;
              beat_nxt = '0;
            end else begin
              beat_nxt = beat_r + lpd_pkg::LPD_BEAT_W'(1);
            end
          end
          lpd_pkg::RUN_BODY: begin
            byte_nxt     = head.data[7:0];
            first_nxt    = 1'b0;
            last_nxt     = head.last;
            drop_nxt     = 1'b0;
            run_last_nxt = 1'b1;
            pop          = 1'b1;
          end
          default: begin
            byte_nxt     = 8'd0;
            first_nxt    = 1'b0;
            last_nxt     = 1'b0;
            drop_nxt     = 1'b1;
            run_last_nxt = 1'b1;
            pop          = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    drop_r     <= drop_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_out_byte      = byte_r;
  assign out_packet_first  = first_r;
  assign out_packet_last   = last_r;
  assign out_frame_dropped = drop_r;
  assign out_run_last      = run_last_r;

endmodule

[hdl/length_prefixed_deframer.sv]
// A result beat passes the run queue, then the output register, after its input.
// Throughput: one input beat per cycle unless in_stall; a header run of four
// result beats drains one per cycle unless out_stall, through a FIFO_DEPTH-entry
// run queue. Input stalls only while that run queue is full.
// Reset is synchronous, active low: clears parse state, queue and output valid,
// and sets max_packet_len to 4096.
`include "length_prefixed_deframer_assert.svh"

module length_prefixed_deframer #(
  parameter int unsigned FIFO_DEPTH = lpd_pkg::LPD_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_chunk_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_out_byte,
  output logic                          out_packet_first,
  output logic                          out_packet_last,
  output logic                          out_frame_dropped,
  output logic                          out_run_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpd_pkg::LPD_LEN_W-1:0] cfg_max_packet_len
);

  logic              fifo_full;
  logic              push;
  lpd_pkg::lpd_run_t push_run;
  logic              pop;
  lpd_pkg::lpd_run_t head;
  logic              head_valid;

  assign in_stall  = fifo_full;
  assign cfg_ready = 1'b1;

  lpd_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_data_byte       (in_data_byte),
    .in_chunk_end       (in_chunk_end),
    .fifo_full          (fifo_full),
    .cfg_valid          (cfg_valid),
    .cfg_max_packet_len (cfg_max_packet_len),
    .push               (push),
    .push_run           (push_run)
  );

  lpd_run_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_run_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  lpd_serializer u_serializer (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_packet_first  (out_packet_first),
    .out_packet_last   (out_packet_last),
    .out_frame_dropped (out_frame_dropped),
    .out_run_last      (out_run_last)
  );

  `LPD_ASSERT_NEVER(a_push_when_full, clk, rst_n, push && fifo_full)
  `LPD_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !head_valid)
  `LPD_ASSERT(a_drop_alone, clk, rst_n,
              out_valid && out_frame_dropped |->
              out_run_last && !out_packet_first && !out_packet_last)
  `LPD_ASSERT(a_first_opens_run, clk, rst_n,
              out_valid && out_packet_first |-> !out_run_last && !out_frame_dropped)

endmodule

[tb/length_prefixed_deframer_tb.sv]
// Testbench for length_prefixed_deframer: drives a byte stream of framed packets,
// predicts the deframed beats with a behavioral model and checks every output beat.
// Depends on lpd_pkg and the length_prefixed_deframer RTL.
`timescale 1ns / 100ps

module length_prefixed_deframer_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef logic [lpd_pkg::LPD_LEN_W-1:0] len_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       dropped;
    logic       run_last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       in_chunk_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_packet_first;
  logic       out_packet_last;
  logic       out_frame_dropped;
  logic       out_run_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  len_t       cfg_max_packet_len = '0;

  // Deframer state as predicted by the testbench.
  logic [31:0] hdr_shift;
  logic [2:0]  hdr_cnt;
  len_t        body_left;
  logic        skipping;
  len_t        max_len;
  out_beat_t   pending_q[$];

  int unsigned tx_idle_pct = IDLE_PCT;
  int unsigned rx_stall_pct = IDLE_PCT;
  bit          hold_armed = 1'b0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned input_stalls = 0;

  length_prefixed_deframer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_chunk_end      (in_chunk_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_packet_first  (out_packet_first),
    .out_packet_last   (out_packet_last),
    .out_frame_dropped (out_frame_dropped),
    .out_run_last      (out_run_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_packet_len(cfg_max_packet_len)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void expect_beat(logic [7:0] data, logic first, logic last,
                                      logic dropped, logic run_last);
    out_beat_t beat;
    beat.data     = data;
    beat.first    = first;
    beat.last     = last;
    beat.dropped  = dropped;
    beat.run_last = run_last;
    pending_q = {pending_q, beat};
  endfunction

  // Advances the predicted state by one accepted byte.
  function automatic void deframe_byte(logic [7:0] b, logic chunk_end);
    logic [31:0] len;
    if (skipping) begin
      if (chunk_end) skipping = 1'b0;
      return;
    end
    if (body_left != 0) begin
      expect_beat(b, 1'b0, body_left == 1, 1'b0, 1'b1);
      body_left = body_left - 1'b1;
      return;
    end
    hdr_shift = {hdr_shift[23:0], b};
    hdr_cnt = hdr_cnt + 1'b1;
    if (hdr_cnt < lpd_pkg::LPD_HDR_LEN) return;
    len = hdr_shift;
    hdr_cnt = '0;
    hdr_shift = '0;
    if (len < lpd_pkg::LPD_HDR_LEN || len > max_len) begin
      expect_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      drops_seen++;
      if (!chunk_end) skipping = 1'b1;
      return;
    end
    for (int k = 0; k < lpd_pkg::LPD_HDR_LEN; k++)
      expect_beat(len[31-8*k -: 8], k == 0,
                  k == lpd_pkg::LPD_HDR_LEN - 1 && len == lpd_pkg::LPD_HDR_LEN,
                  1'b0, k == lpd_pkg::LPD_HDR_LEN - 1);
    body_left = len_t'(len - lpd_pkg::LPD_HDR_LEN);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic chunk_end);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_chunk_end <= chunk_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    deframe_byte(b, chunk_end);
  endtask

  task automatic send_header(input logic [31:0] len, input logic [3:0] ends);
    for (int k = 0; k < lpd_pkg::LPD_HDR_LEN; k++)
      send_byte(len[31-8*k -: 8], ends[3-k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input len_t value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_max_packet_len <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len = value;
  endtask

  // Sends one frame, good, bad or broken, then finishes whatever is left open.
  task automatic send_random_frame();
    logic [31:0] len;
    logic [3:0]  ends;
    int          pick;
    int unsigned span;
    pick = $urandom_range(99);
    for (int k = 0; k < 4; k++) ends[k] = ($urandom_range(99) < 8);
    if (pick < 6) begin
      repeat ($urandom_range(3, 1))
        send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
    end else if (pick < 20) begin
      case ($urandom_range(2))
        0:       len = $urandom_range(3);
        1:       len = max_len + 1 + $urandom_range(7);
        default: len = $urandom;
      endcase
      send_header(len, ends);
    end else begin
      span = (max_len < lpd_pkg::LPD_HDR_LEN + 16) ? 0 : 16;
      if (max_len >= lpd_pkg::LPD_HDR_LEN && max_len < lpd_pkg::LPD_HDR_LEN + 16)
        span = max_len - lpd_pkg::LPD_HDR_LEN;
      if (max_len >= lpd_pkg::LPD_HDR_LEN && max_len <= 64 && $urandom_range(99) < 8)
        len = 32'(max_len);
      else
        len = lpd_pkg::LPD_HDR_LEN + $urandom_range(span);
      send_header(len, ends);
    end
    while (skipping || hdr_cnt != 0 || body_left != 0)
      send_byte(8'($urandom_range(255)), $urandom_range(99) < 12);
  endtask

  task automatic test_directed_framing();
    send_header(32'd4, 4'b0000);
    send_header(32'd6, 4'b0000);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_header(32'd5, 4'b0100);
    send_byte(8'hA5, 1'b1);
    send_header(32'd0, 4'b0001);
    send_header(32'd3, 4'b0000);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h04, 1'b1);
    send_header(32'hFFFF_FFFF, 4'b0001);
    send_header(32'd4097, 4'b0001);
  endtask

  task automatic test_limit_extremes();
    write_limit(17'd4);
    send_header(32'd4, 4'b0000);
    send_header(32'd5, 4'b0001);
    write_limit(17'd0);
    send_header(32'd4, 4'b0001);
    write_limit(17'd65536);
    send_header(32'd65537, 4'b0001);
    send_header(32'd8, 4'b0000);
    repeat (4) send_byte(8'($urandom_range(255)), 1'b0);
    write_limit(17'h1FFFF);
    send_header(32'h0002_0000, 4'b0001);
    send_header(32'd5, 4'b0000);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) send_random_frame();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    test_random(30);
    hold_armed = 1'b1;
    while (hold_count < HOLD_CYCLES) send_random_frame();
    tx_idle_pct = IDLE_PCT;
    rx_stall_pct = IDLE_PCT;
  endtask

  task automatic test_sender_pause();
    test_random(15);
    wait_drained();
    test_random(15);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && in_valid && in_stall) input_stalls++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output beat: out_byte %0h, frame_dropped %0b",
               out_out_byte, out_frame_dropped);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        beats_checked++;
        if (!want.dropped) check_field("out_byte", want.data, out_out_byte);
        check_field("packet_first", 8'(want.first), 8'(out_packet_first));
        check_field("packet_last", 8'(want.last), 8'(out_packet_last));
        check_field("frame_dropped", 8'(want.dropped), 8'(out_frame_dropped));
        check_field("run_last", 8'(want.run_last), 8'(out_run_last));
      end
    end
  end

  // The limit is many times the slowest legal run of this stimulus.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.",
               cycle_count, pending_q.size());
      $display("length_prefixed_deframer test failed");
      $finish;
    end
  end

  initial begin
    hdr_shift = '0;
    hdr_cnt = '0;
    body_left = '0;
    skipping = 1'b0;
    max_len = lpd_pkg::LPD_MAX_LEN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_framing();
    test_limit_extremes();
    write_limit(17'd48);
    test_random(90);
    test_backpressure();
    test_sender_pause();
    write_limit(17'd600);
    test_random(40);
    write_limit(17'd4);
    test_random(20);
    write_limit(lpd_pkg::LPD_MAX_LEN_RESET);
    test_random(30);
    wait_drained();

    $display("Sent %0d bytes, checked %0d output beats, %0d dropped frames.",
             items_sent, beats_checked, drops_seen);
    $display("Limits 0 to 131071 exercised; input held back for %0d cycles.",
             input_stalls);
    if (err_count == 0) begin
      $display("length_prefixed_deframer test passed");
    end else begin
      $display("length_prefixed_deframer test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/lpd_pkg.sv
hdl/lpd_parser.sv
hdl/lpd_run_fifo.sv
hdl/lpd_serializer.sv
hdl/length_prefixed_deframer.sv
tb/length_prefixed_deframer_tb.sv
